// ===== rtl/core/swg_pkg.sv =====
package swg_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int VW         = 64;
  localparam int LEN_W      = 31;
  localparam int NRM_W      = 18;
  localparam int CORNER_W   = 2;

  localparam logic [LEN_W-1:0]    GRAV_RST    = 31'd642253;
  localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_NONE = 2'd3;
  localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;

  // input tdata layout, lowest bit first
  localparam int O_VS   = 0;
  localparam int O_VX   = O_VS + DATA_WIDTH;
  localparam int O_VY   = O_VX + DATA_WIDTH;
  localparam int O_ES   = O_VY + DATA_WIDTH;
  localparam int O_EB   = O_ES + DATA_WIDTH;
  localparam int O_LEN  = O_EB + DATA_WIDTH;
  localparam int O_NX   = O_LEN + LEN_W;
  localparam int O_NY   = O_NX + NRM_W;
  localparam int O_CS   = O_NY + NRM_W;
  localparam int O_CB   = O_CS + DATA_WIDTH;
  localparam int O_AREA = O_CB + DATA_WIDTH;
  localparam int IN_BITS     = O_AREA + LEN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

  localparam int NUM_W     = VW + FRAC_BITS;
  localparam int RF_DEPTH  = 32;
  localparam int RA_W      = $clog2(RF_DEPTH);
  localparam int PC_W      = 6;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] MAG_OVER = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_LOAD = 4'd0,
    OP_CLR0 = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_MUL  = 4'd4,
    OP_DIV  = 4'd5,
    OP_HALF = 4'd6,
    OP_SKIP = 4'd7,
    OP_TEST = 4'd8,
    OP_OUT  = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    F_VS   = 4'd0,
    F_VX   = 4'd1,
    F_VY   = 4'd2,
    F_ES   = 4'd3,
    F_EB   = 4'd4,
    F_LEN  = 4'd5,
    F_NX   = 4'd6,
    F_NY   = 4'd7,
    F_CS   = 4'd8,
    F_CB   = 4'd9,
    F_AREA = 4'd10,
    F_G    = 4'd11,
    F_ZERO = 4'd12
  } fld_t;

  typedef struct packed {
    op_t             op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] sa;
    logic [RA_W-1:0] sb;
    fld_t            fld;
    logic            coff;
    logic [PC_W-1:0] tgt;
  } uinstr_t;

  // register file map
  localparam logic [RA_W-1:0] R_HS0  = 5'd0;
  localparam logic [RA_W-1:0] R_HS1  = 5'd1;
  localparam logic [RA_W-1:0] R_HS2  = 5'd2;
  localparam logic [RA_W-1:0] R_HX0  = 5'd3;
  localparam logic [RA_W-1:0] R_HX1  = 5'd4;
  localparam logic [RA_W-1:0] R_HX2  = 5'd5;
  localparam logic [RA_W-1:0] R_HY0  = 5'd6;
  localparam logic [RA_W-1:0] R_HY1  = 5'd7;
  localparam logic [RA_W-1:0] R_HY2  = 5'd8;
  localparam logic [RA_W-1:0] R_SX   = 5'd9;
  localparam logic [RA_W-1:0] R_SY   = 5'd10;
  localparam logic [RA_W-1:0] R_H    = 5'd11;
  localparam logic [RA_W-1:0] R_T    = 5'd12;
  localparam logic [RA_W-1:0] R_P    = 5'd13;
  localparam logic [RA_W-1:0] R_DX1  = 5'd14;
  localparam logic [RA_W-1:0] R_DX2  = 5'd15;
  localparam logic [RA_W-1:0] R_DY1  = 5'd16;
  localparam logic [RA_W-1:0] R_DY2  = 5'd17;
  localparam logic [RA_W-1:0] R_DW1  = 5'd18;
  localparam logic [RA_W-1:0] R_DW2  = 5'd19;
  localparam logic [RA_W-1:0] R_DET  = 5'd20;
  localparam logic [RA_W-1:0] R_AREA = 5'd21;
  localparam logic [RA_W-1:0] R_DEP  = 5'd22;
  localparam logic [RA_W-1:0] R_WX   = 5'd23;
  localparam logic [RA_W-1:0] R_WY   = 5'd24;
  localparam logic [RA_W-1:0] R_G    = 5'd25;
  localparam logic [RA_W-1:0] R_PX   = 5'd27;
  localparam logic [RA_W-1:0] R_PY   = 5'd28;
  localparam logic [RA_W-1:0] R_Z    = 5'd31;

  localparam logic [PC_W-1:0] PC_CLRS = 6'd55;

  function automatic logic [VW-1:0] mag(val_t v);
    logic [VW-1:0] u;
    u = v;
    return v[VW-1] ? (~u + 64'd1) : u;
  endfunction

  function automatic val_t from_mag(logic [VW-1:0] m, logic neg);
    logic [VW-1:0] lim;
    logic [VW-1:0] mm;
    lim = neg ? MAG_OVER : VMAX;
    mm  = (m > lim) ? lim : m;
    return neg ? val_t'(~mm + 64'd1) : val_t'(mm);
  endfunction

  function automatic val_t sadd(val_t a, val_t b);
    logic [VW:0] s;
    val_t        r;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) r = s[VW] ? VMIN : VMAX;
    else                  r = val_t'(s[VW-1:0]);
    return r;
  endfunction

  function automatic val_t ssub(val_t a, val_t b);
    logic [VW:0] s;
    val_t        r;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) r = s[VW] ? VMIN : VMAX;
    else                  r = val_t'(s[VW-1:0]);
    return r;
  endfunction

  // divide by two, rounded toward zero
  function automatic val_t half(val_t a);
    val_t t;
    t = a + val_t'({{(VW-1){1'b0}}, a[VW-1]});
    return t >>> 1;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] sat_out(val_t v);
    val_t hi;
    val_t lo;
    logic [DATA_WIDTH-1:0] r;
    hi = {{(VW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi)      r = hi[DATA_WIDTH-1:0];
    else if (v < lo) r = lo[DATA_WIDTH-1:0];
    else             r = v[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic val_t ext_data(logic [DATA_WIDTH-1:0] x);
    return {{(VW-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
  endfunction

  function automatic uinstr_t mk(op_t op, logic [RA_W-1:0] dst, logic [RA_W-1:0] sa,
                                 logic [RA_W-1:0] sb, fld_t fld, logic coff);
    uinstr_t u;
    u.op   = op;
    u.dst  = dst;
    u.sa   = sa;
    u.sb   = sb;
    u.fld  = fld;
    u.coff = coff;
    u.tgt  = PC_CLRS;
    return u;
  endfunction

  // microprogram
  function automatic uinstr_t rom(logic [PC_W-1:0] pc);
    uinstr_t u;
    case (pc)
      6'd0:  u = mk(OP_LOAD, R_HS0, R_Z, R_Z, F_VS, 1'b1);
      6'd1:  u = mk(OP_LOAD, R_HX0, R_Z, R_Z, F_VX, 1'b1);
      6'd2:  u = mk(OP_LOAD, R_HY0, R_Z, R_Z, F_VY, 1'b1);
      6'd3:  u = mk(OP_CLR0, R_SX, R_Z, R_Z, F_ZERO, 1'b0);
      6'd4:  u = mk(OP_CLR0, R_SY, R_Z, R_Z, F_ZERO, 1'b0);
      6'd5:  u = mk(OP_LOAD, R_H, R_Z, R_Z, F_ES, 1'b0);
      6'd6:  u = mk(OP_LOAD, R_T, R_Z, R_Z, F_EB, 1'b0);
      6'd7:  u = mk(OP_SUB, R_H, R_H, R_T, F_ZERO, 1'b0);
      6'd8:  u = mk(OP_MUL, R_T, R_H, R_H, F_ZERO, 1'b0);
      6'd9:  u = mk(OP_LOAD, R_P, R_Z, R_Z, F_LEN, 1'b0);
      6'd10: u = mk(OP_MUL, R_T, R_T, R_P, F_ZERO, 1'b0);
      6'd11: u = mk(OP_LOAD, R_P, R_Z, R_Z, F_NX, 1'b0);
      6'd12: u = mk(OP_MUL, R_P, R_T, R_P, F_ZERO, 1'b0);
      6'd13: u = mk(OP_ADD, R_SX, R_SX, R_P, F_ZERO, 1'b0);
      6'd14: u = mk(OP_LOAD, R_P, R_Z, R_Z, F_NY, 1'b0);
      6'd15: u = mk(OP_MUL, R_P, R_T, R_P, F_ZERO, 1'b0);
      6'd16: u = mk(OP_ADD, R_SY, R_SY, R_P, F_ZERO, 1'b0);
      6'd17: u = mk(OP_SKIP, R_Z, R_Z, R_Z, F_ZERO, 1'b0);
      6'd18: u = mk(OP_SUB, R_DX1, R_HX1, R_HX0, F_ZERO, 1'b0);
      6'd19: u = mk(OP_SUB, R_DX2, R_HX2, R_HX0, F_ZERO, 1'b0);
      6'd20: u = mk(OP_SUB, R_DY1, R_HY1, R_HY0, F_ZERO, 1'b0);
      6'd21: u = mk(OP_SUB, R_DY2, R_HY2, R_HY0, F_ZERO, 1'b0);
      6'd22: u = mk(OP_SUB, R_DW1, R_HS1, R_HS0, F_ZERO, 1'b0);
      6'd23: u = mk(OP_SUB, R_DW2, R_HS2, R_HS0, F_ZERO, 1'b0);
      6'd24: u = mk(OP_MUL, R_H, R_DY2, R_DX1, F_ZERO, 1'b0);
      6'd25: u = mk(OP_MUL, R_T, R_DY1, R_DX2, F_ZERO, 1'b0);
      6'd26: u = mk(OP_SUB, R_DET, R_H, R_T, F_ZERO, 1'b0);
      6'd27: u = mk(OP_LOAD, R_AREA, R_Z, R_Z, F_AREA, 1'b0);
      6'd28: u = mk(OP_TEST, R_Z, R_DET, R_AREA, F_ZERO, 1'b0);
      6'd29: u = mk(OP_LOAD, R_DEP, R_Z, R_Z, F_CS, 1'b0);
      6'd30: u = mk(OP_LOAD, R_H, R_Z, R_Z, F_CB, 1'b0);
      6'd31: u = mk(OP_SUB, R_DEP, R_DEP, R_H, F_ZERO, 1'b0);
      6'd32: u = mk(OP_MUL, R_H, R_DY2, R_DW1, F_ZERO, 1'b0);
      6'd33: u = mk(OP_MUL, R_T, R_DY1, R_DW2, F_ZERO, 1'b0);
      6'd34: u = mk(OP_SUB, R_H, R_H, R_T, F_ZERO, 1'b0);
      6'd35: u = mk(OP_DIV, R_WX, R_H, R_DET, F_ZERO, 1'b0);
      6'd36: u = mk(OP_MUL, R_H, R_DX1, R_DW2, F_ZERO, 1'b0);
      6'd37: u = mk(OP_MUL, R_T, R_DX2, R_DW1, F_ZERO, 1'b0);
      6'd38: u = mk(OP_SUB, R_H, R_H, R_T, F_ZERO, 1'b0);
      6'd39: u = mk(OP_DIV, R_WY, R_H, R_DET, F_ZERO, 1'b0);
      6'd40: u = mk(OP_LOAD, R_G, R_Z, R_Z, F_G, 1'b0);
      6'd41: u = mk(OP_MUL, R_H, R_G, R_WX, F_ZERO, 1'b0);
      6'd42: u = mk(OP_MUL, R_H, R_H, R_DEP, F_ZERO, 1'b0);
      6'd43: u = mk(OP_SUB, R_PX, R_Z, R_H, F_ZERO, 1'b0);
      6'd44: u = mk(OP_MUL, R_H, R_G, R_WY, F_ZERO, 1'b0);
      6'd45: u = mk(OP_MUL, R_H, R_H, R_DEP, F_ZERO, 1'b0);
      6'd46: u = mk(OP_SUB, R_PY, R_Z, R_H, F_ZERO, 1'b0);
      6'd47: u = mk(OP_MUL, R_H, R_G, R_SX, F_ZERO, 1'b0);
      6'd48: u = mk(OP_HALF, R_H, R_H, R_Z, F_ZERO, 1'b0);
      6'd49: u = mk(OP_DIV, R_H, R_H, R_AREA, F_ZERO, 1'b0);
      6'd50: u = mk(OP_ADD, R_PX, R_PX, R_H, F_ZERO, 1'b0);
      6'd51: u = mk(OP_MUL, R_H, R_G, R_SY, F_ZERO, 1'b0);
      6'd52: u = mk(OP_HALF, R_H, R_H, R_Z, F_ZERO, 1'b0);
      6'd53: u = mk(OP_DIV, R_H, R_H, R_AREA, F_ZERO, 1'b0);
      6'd54: u = mk(OP_ADD, R_PY, R_PY, R_H, F_ZERO, 1'b0);
      6'd55: u = mk(OP_LOAD, R_SX, R_Z, R_Z, F_ZERO, 1'b0);
      6'd56: u = mk(OP_LOAD, R_SY, R_Z, R_Z, F_ZERO, 1'b0);
      default: u = mk(OP_OUT, R_Z, R_PX, R_PY, F_ZERO, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/shallow_water_gravity_term.sv =====
// Gravity momentum term of a shallow-water solver, one triangle per three corner items
// (tuser = corner 0, 1, 2; corner 3 is taken and ignored). Corner 2 yields one result:
// x and y momentum deltas in saturated Q16.16 and a degenerate flag. A microcoded
// sequencer drives a 32-entry register file, a multiplier that sums 32x32-bit partial
// products and a bit-serial divider. No item is accepted while one is in work; corner 2
// also runs the four divisions, which a degenerate triangle skips, and waits for the
// previous result to be taken. After reset the register file is cleared, and no item
// is accepted while the clear is in progress.
// Gravity may be written only when idle.
module shallow_water_gravity_term import swg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [LEN_W-1:0]           cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // vertex_stage, vertex_x, vertex_y, edge_stage, edge_bed, edge_length, normal_x,
  // normal_y, centroid_stage, centroid_bed, cell_area
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  // corner
  input  logic [CORNER_W-1:0]        in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // xmom_delta, ymom_delta
  output logic [OUT_TDATA_W-1:0]     out_tdata,
  // degenerate
  output logic                       out_tuser
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic [CORNER_W-1:0]      corner_r, corner_nxt;
  logic [IN_TDATA_W-1:0]    item_r, item_nxt;
  logic [LEN_W-1:0]         grav_r;
  logic                     degen_r, degen_nxt;
  logic [RA_W-1:0]          clr_r, clr_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic                     out_tuser_r, out_tuser_nxt;

  uinstr_t         ins;
  logic            we;
  logic [RA_W-1:0] waddr, wdst;
  val_t            wdata, rd_a, rd_b, fv;
  logic            mul_start, div_start, mul_done, div_done;
  val_t            mul_y, div_y;

  assign ins  = rom(pc_r);
  assign wdst = ins.dst + (ins.coff ? RA_W'(corner_r) : '0);

  swg_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ins.sa), .rdata(rd_a)
  );
  swg_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ins.sb), .rdata(rd_b)
  );

  swg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(rd_a), .b(rd_b),
    .done(mul_done), .y(mul_y)
  );
  swg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(rd_a), .b(rd_b),
    .done(div_done), .y(div_y)
  );

  always_comb begin
    case (ins.fld)
      F_VS:    fv = ext_data(item_r[O_VS +: DATA_WIDTH]);
      F_VX:    fv = ext_data(item_r[O_VX +: DATA_WIDTH]);
      F_VY:    fv = ext_data(item_r[O_VY +: DATA_WIDTH]);
      F_ES:    fv = ext_data(item_r[O_ES +: DATA_WIDTH]);
      F_EB:    fv = ext_data(item_r[O_EB +: DATA_WIDTH]);
      F_LEN:   fv = {{(VW-LEN_W){1'b0}}, item_r[O_LEN +: LEN_W]};
      F_NX:    fv = {{(VW-NRM_W){item_r[O_NX+NRM_W-1]}}, item_r[O_NX +: NRM_W]};
      F_NY:    fv = {{(VW-NRM_W){item_r[O_NY+NRM_W-1]}}, item_r[O_NY +: NRM_W]};
      F_CS:    fv = ext_data(item_r[O_CS +: DATA_WIDTH]);
      F_CB:    fv = ext_data(item_r[O_CB +: DATA_WIDTH]);
      F_AREA:  fv = {{(VW-LEN_W){1'b0}}, item_r[O_AREA +: LEN_W]};
      F_G:     fv = {{(VW-LEN_W){1'b0}}, grav_r};
      default: fv = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    corner_nxt     = corner_r;
    item_nxt       = item_r;
    degen_nxt      = degen_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    we             = 1'b0;
    waddr          = wdst;
    wdata          = '0;
    mul_start      = 1'b0;
    div_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == RA_W'(RF_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          item_nxt   = in_tdata;
          corner_nxt = in_tuser;
          pc_nxt     = '0;
          if (in_tuser != CORNER_NONE) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_READ;
        unique case (ins.op)
          OP_LOAD: begin
            we    = 1'b1;
            wdata = fv;
          end
          OP_CLR0: begin
            we = (corner_r == CORNER_FIRST);
          end
          OP_ADD: begin
            we    = 1'b1;
            wdata = sadd(rd_a, rd_b);
          end
          OP_SUB: begin
            we    = 1'b1;
            wdata = ssub(rd_a, rd_b);
          end
          OP_HALF: begin
            we    = 1'b1;
            wdata = half(rd_a);
          end
          OP_MUL: begin
            mul_start = 1'b1;
            pc_nxt    = pc_r;
            state_nxt = ST_WAIT;
          end
          OP_DIV: begin
            div_start = 1'b1;
            pc_nxt    = pc_r;
            state_nxt = ST_WAIT;
          end
          OP_SKIP: begin
            if (corner_r != CORNER_LAST) begin
              state_nxt = ST_IDLE;
            end
          end
          OP_TEST: begin
            degen_nxt = (rd_a == '0) || (rd_b == '0);
            if (degen_nxt) begin
              pc_nxt = ins.tgt;
            end
          end
          OP_OUT: begin
            pc_nxt = pc_r;
            if (!out_tvalid_r || out_tready) begin
              out_tvalid_nxt = 1'b1;
              out_tuser_nxt  = degen_r;
              out_tdata_nxt  = degen_r ? '0 : {sat_out(rd_b), sat_out(rd_a)};
              state_nxt      = ST_IDLE;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_WAIT: begin
        if ((ins.op == OP_MUL) ? mul_done : div_done) begin
          we        = 1'b1;
          wdata     = (ins.op == OP_MUL) ? mul_y : div_y;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      pc_r         <= '0;
      corner_r     <= '0;
      degen_r      <= 1'b0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      grav_r       <= GRAV_RST;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      corner_r     <= corner_nxt;
      degen_r      <= degen_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        grav_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/core/swg_ram.sv =====
module swg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/swg_mul.sv =====
module swg_mul import swg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t y
);

  logic [VW-1:0]   ua_r, ub_r;
  logic            neg_r;
  logic [2*VW-1:0] acc_r;
  logic [1:0]      step_r;
  logic            busy_r, done_r;
  logic [31:0]     pa, pb;
  logic [63:0]     pp;
  logic [2*VW-1:0] pp_sh;

  always_comb begin
    case (step_r)
      2'd0: begin pa = ua_r[31:0];  pb = ub_r[31:0];  pp_sh = '0; end
      2'd1: begin pa = ua_r[31:0];  pb = ub_r[63:32]; pp_sh = '0; end
      2'd2: begin pa = ua_r[63:32]; pb = ub_r[31:0];  pp_sh = '0; end
      default: begin pa = ua_r[63:32]; pb = ub_r[63:32]; pp_sh = '0; end
    endcase
    pp = pa * pb;
    case (step_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= mag(a);
      ub_r  <= mag(b);
      neg_r <= a[VW-1] ^ b[VW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign y = from_mag((|acc_r[2*VW-1:VW+FRAC_BITS]) ? MAG_OVER : acc_r[VW+FRAC_BITS-1:FRAC_BITS],
                      neg_r);

endmodule

// ===== rtl/core/swg_div.sv =====
module swg_div import swg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t y
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [VW-1:0]    d_r;
  logic [NUM_W-1:0] num_r, q_r;
  logic [VW:0]      rem_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [VW:0]      r1;
  logic             ge;

  assign r1 = {rem_r[VW-1:0], num_r[NUM_W-1]};
  assign ge = r1 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= mag(b);
      num_r <= {mag(a), {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= a[VW-1] ^ b[VW-1];
    end else if (busy_r) begin
      rem_r <= ge ? (r1 - {1'b0, d_r}) : r1;
      q_r   <= {q_r[NUM_W-2:0], ge};
      num_r <= {num_r[NUM_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign y = from_mag((|q_r[NUM_W-1:VW]) ? MAG_OVER : q_r[VW-1:0], neg_r);

endmodule

// ===== rtl/core/swg_chk.sv =====
module swg_chk import swg_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [CORNER_W-1:0]    in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero deltas");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != CORNER_NONE) |=> !in_tready)
    else $error("ready right after taking a corner item");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind shallow_water_gravity_term swg_chk u_swg_chk (.*);
